[hdl/aes_pkg.sv]
// aes_pkg: shared constants, types and byte functions for the aes-128 encryptor
// used by aes_round_cell and aes128_block_encrypt; depends on nothing
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned IdxW = 1;
  localparam logic [IdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [IdxW-1:0] RegKeyLow = 1'b1;
  localparam logic [7:0] Poly = 8'h1b;
  localparam logic [7:0] Rcon0 = 8'h01;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   vld;
    logic   last;
    logic [7:0] rcon;
    block_t st;
    block_t rk;
  } cell_bus_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? Poly : 8'h00);
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    get_byte = b[BlockW-1-8*i -: 8];
  endfunction

endpackage
`default_nettype wire

[hdl/aes128_block_encrypt.sv]
// aes128_block_encrypt: pipelined aes-128 encryptor, one round cell per round
// depends on aes_pkg and aes_round_cell
`default_nettype none
// usage
//   s_axis: plaintext beats, tdata = plaintext_high in bits 63:0, plaintext_low in bits 127:64
//   m_axis: ciphertext beats, same packing with ciphertext fields
//   cfg: cfg_we / cfg_index / cfg_wdata; index 0 key_high, index 1 key_low
//   write the key only while no beat is in flight
// pipeline: 11 register stages (one add-key stage, then ten round cells each
//   carrying its round key); an accepted beat passes the add-key register and
//   then each round cell in order before it is shown on m_axis
// throughput: one block per cycle while m_axis does not stall; the row of round cells advances together
// stall: when m_axis_tready is low with a result waiting, the whole row holds
//   and s_axis_tready drops; bubbles in the row are not squeezed out, the row
//   only moves as a whole
// reset: clears all valid flags and both key registers to zero
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BlockW-1:0] s_axis_tdata,   // plaintext_high, plaintext_low
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [BlockW-1:0]      m_axis_tdata,   // ciphertext_high, ciphertext_low
  input  wire logic              cfg_we,
  input  wire logic [IdxW-1:0]   cfg_index,
  input  wire logic [HalfW-1:0]  cfg_wdata
);

  logic [HalfW-1:0] key_high;
  logic [HalfW-1:0] key_low;
  cell_bus_t        bus [NumRounds+1];
  logic             en;
  block_t           key;
  block_t           pt;

  // whole row moves unless the last cell holds an untaken result
  assign en = !bus[NumRounds].vld || m_axis_tready;
  assign s_axis_tready = en;
  assign key = {key_high, key_low};
  assign pt  = {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyHigh: key_high <= cfg_wdata;
        RegKeyLow:  key_low  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // initial add-round-key stage
  always_ff @(posedge clk) begin
    if (rst) begin
      bus[0].vld <= 1'b0;
    end else if (en) begin
      bus[0].vld <= s_axis_tvalid;
    end
    if (en) begin
      bus[0].last <= 1'b0;
      bus[0].rcon <= Rcon0;
      bus[0].st   <= pt ^ key;
      bus[0].rk   <= key;
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    cell_bus_t cin;
    always_comb begin
      cin = bus[g];
      cin.last = (g == NumRounds - 1);
    end
    aes_round_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (cin),
      .dout (bus[g+1])
    );
  end

  assign m_axis_tvalid = bus[NumRounds].vld;
  assign m_axis_tdata  = {bus[NumRounds].st[HalfW-1:0], bus[NumRounds].st[BlockW-1:HalfW]};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");
  a_zero_in: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> $stable(bus[0].st))
    else $error("first stage moved during stall");
`endif

endmodule
`default_nettype wire

[hdl/aes_round_cell.sv]
// aes_round_cell: one registered aes round plus the matching key schedule step
// depends on aes_pkg
`default_nettype none
module aes_round_cell
  import aes_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire cell_bus_t din,
  output cell_bus_t      dout
);

  block_t    sr;
  block_t    mc;
  block_t    nk;
  block_t    st_next;
  logic [7:0] w [4];

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[BlockW-1-8*(r+4*c) -: 8] = SBOX[get_byte(din.st, r + 4*((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(sr, 4*c);
      a1 = get_byte(sr, 4*c+1);
      a2 = get_byte(sr, 4*c+2);
      a3 = get_byte(sr, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[BlockW-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mc[BlockW-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[BlockW-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[BlockW-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    // next round key from the current one
    w[0] = SBOX[get_byte(din.rk, 13)] ^ din.rcon;
    w[1] = SBOX[get_byte(din.rk, 14)];
    w[2] = SBOX[get_byte(din.rk, 15)];
    w[3] = SBOX[get_byte(din.rk, 12)];
    for (int i = 0; i < 4; i++) begin
      nk[BlockW-1-8*i -: 8] = get_byte(din.rk, i) ^ w[i];
    end
    for (int i = 4; i < 16; i++) begin
      nk[BlockW-1-8*i -: 8] = get_byte(din.rk, i) ^ nk[BlockW-1-8*(i-4) -: 8];
    end
    st_next = (din.last ? sr : mc) ^ nk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.last <= din.last;
      dout.rcon <= xtime(din.rcon);
      dout.st   <= st_next;
      dout.rk   <= nk;
    end
  end

endmodule
`default_nettype wire
